// File: rtl/gtg_pkg.sv
`default_nettype none
package gtg_pkg;

   localparam int CordicSteps = 16;
   localparam int Steps = (CordicSteps > 24) ? 24 : CordicSteps;

   localparam int VW = 30;
   localparam int AW = 22;

   localparam logic signed [AW-1:0] AngPi     = AW'(205887);
   localparam logic signed [AW-1:0] AngHalfPi = AW'(102944);
   localparam logic signed [AW-1:0] AngTwoPi  = AW'(411774);
   localparam logic [15:0]          CordicGain = 16'd39797;

   localparam logic [2:0] RegGoalX   = 3'd0;
   localparam logic [2:0] RegGoalY   = 3'd1;
   localparam logic [2:0] RegStop    = 3'd2;
   localparam logic [2:0] RegLinGain = 3'd3;
   localparam logic [2:0] RegAngGain = 3'd4;

   typedef struct packed {
      logic signed [15:0] goal_x;
      logic signed [15:0] goal_y;
      logic [15:0]        stop_distance;
      logic [7:0]         linear_gain;
      logic [7:0]         angular_gain;
   } cfg_type;

   function automatic logic signed [AW-1:0] atan_entry(input int i);
      logic signed [AW-1:0] r;
      begin
         unique case (i)
            0: r = AW'(51472);
            1: r = AW'(30386);
            2: r = AW'(16055);
            3: r = AW'(8150);
            4: r = AW'(4091);
            5: r = AW'(2047);
            6: r = AW'(1024);
            7: r = AW'(512);
            8: r = AW'(256);
            9: r = AW'(128);
            10: r = AW'(64);
            11: r = AW'(32);
            12: r = AW'(16);
            13: r = AW'(8);
            14: r = AW'(4);
            15: r = AW'(2);
            16: r = AW'(1);
            default: r = '0;
         endcase
         return r;
      end
   endfunction

endpackage
`default_nettype wire

// File: rtl/go_to_goal_velocity_controller_core.sv
// Throughput: one beat per cycle; a stall on rsp freezes the whole pipeline.
// Reset: synchronous, active high; clears all valid bits and loads register defaults
// (goal 0, stop_distance 1, linear_gain 179, angular_gain 128).
`default_nettype none
module go_to_goal_velocity_controller_core
   import gtg_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [47:0] req_tdata,   // pose_x[15:0], pose_y[31:16], pose_heading[46:32]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata,   // forward_speed[16:0], turn_rate[32:17], at_goal[33]
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_index,
   input  wire logic [15:0] csr_wdata
);
   localparam int NV = 3 + Steps;
   localparam int NT = NV + Steps + 4;

   cfg_type cfg_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{16'sd0, 16'sd0, 16'd1, 8'd179, 8'd128};
      end else if (csr_we) begin
         unique case (csr_index)
            RegGoalX:   cfg_ff.goal_x <= csr_wdata;
            RegGoalY:   cfg_ff.goal_y <= csr_wdata;
            RegStop:    cfg_ff.stop_distance <= csr_wdata;
            RegLinGain: cfg_ff.linear_gain <= csr_wdata[7:0];
            RegAngGain: cfg_ff.angular_gain <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   logic en;
   logic [NT-1:0] v_ff;
   assign en = !v_ff[NT-1] || rsp_tready;
   assign req_tready = en;
   always_ff @(posedge clock) begin
      if (reset) v_ff <= '0;
      else if (en) v_ff <= {v_ff[NT-2:0], req_tvalid};
   end

   // heading, Q.16, carried alongside
   logic signed [AW-1:0] hd_ff [NV-1];

   // stage 0: error vector
   logic signed [16:0] ex0_ff, ey0_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         ex0_ff <= 17'(cfg_ff.goal_x) - 17'($signed(req_tdata[15:0]));
         ey0_ff <= 17'(cfg_ff.goal_y) - 17'($signed(req_tdata[31:16]));
         hd_ff[0] <= AW'($signed(req_tdata[46:32])) <<< 4;
      end
   end

   // stage 1: pre-rotation into right half plane
   logic signed [VW-1:0] vx [Steps+1];
   logic signed [VW-1:0] vy [Steps+1];
   logic signed [AW-1:0] vz [Steps+1];
   logic                 nz_ff [1:NV-2];
   always_ff @(posedge clock) begin
      if (en) begin
         nz_ff[1] <= (ex0_ff != '0) || (ey0_ff != '0);
         if (ex0_ff[16]) begin
            vx[0] <= -(VW'(ex0_ff) <<< 8);
            vy[0] <= -(VW'(ey0_ff) <<< 8);
            vz[0] <= ey0_ff[16] ? -AngPi : AngPi;
         end else begin
            vx[0] <= VW'(ex0_ff) <<< 8;
            vy[0] <= VW'(ey0_ff) <<< 8;
            vz[0] <= '0;
         end
      end
   end

   for (genvar i = 0; i < Steps; i++) begin : g_vec
      gtg_vec_stage u_vec (
         .clock, .en, .idx(5'(i)),
         .x_in(vx[i]), .y_in(vy[i]), .z_in(vz[i]),
         .x_ff(vx[i+1]), .y_ff(vy[i+1]), .z_ff(vz[i+1])
      );
   end

   for (genvar s = 1; s < NV-1; s++) begin : g_hd
      always_ff @(posedge clock) begin
         if (en) hd_ff[s] <= hd_ff[s-1];
      end
   end
   for (genvar s = 2; s < NV-1; s++) begin : g_nz
      always_ff @(posedge clock) begin
         if (en) nz_ff[s] <= nz_ff[s-1];
      end
   end

   // stage: distance multiply and bearing error
   logic [46:0] dprod_ff;
   logic signed [AW-1:0] err_ff;
   logic [VW-1:0] mag;
   assign mag = nz_ff[NV-2] ? vx[Steps] : '0;
   always_ff @(posedge clock) begin
      if (en) begin
         dprod_ff <= 47'(mag) * 47'(CordicGain) + 47'(1 << 23);
         err_ff <= (nz_ff[NV-2] ? vz[Steps] : AW'(0)) - hd_ff[NV-2];
      end
   end

   // angle reduction and fold
   logic [22:0] dist_c;
   assign dist_c = dprod_ff[46:24];
   logic signed [AW+1:0] r0, r1, r2, r3, r4;
   function automatic logic signed [AW+1:0] wrap1(input logic signed [AW+1:0] a);
      if (a > (AW+2)'(AngPi)) return a - (AW+2)'(AngTwoPi);
      else if (a < -(AW+2)'(AngPi)) return a + (AW+2)'(AngTwoPi);
      else return a;
   endfunction
   assign r0 = (AW+2)'(err_ff);
   assign r1 = wrap1(r0);
   assign r2 = wrap1(r1);
   assign r3 = wrap1(r2);
   assign r4 = wrap1(r3);

   logic [22:0] dist_ff [NV+1:NT-3];
   logic signed [AW-1:0] erk_ff [NV+1:NT-3];
   logic ag_ff [NV+1:NT-3];
   logic neg_ff [NV+1:NT-3];
   logic signed [19:0] rx [Steps+1];
   logic signed [19:0] ry [Steps+1];
   logic signed [AW-1:0] ra [Steps+1];
   always_ff @(posedge clock) begin
      if (en) begin
         dist_ff[NV+1] <= dist_c;
         erk_ff[NV+1] <= err_ff;
         ag_ff[NV+1] <= dist_c < 23'(cfg_ff.stop_distance);
         rx[0] <= 20'(CordicGain);
         ry[0] <= '0;
         if (r4 > (AW+2)'(AngHalfPi)) begin
            ra[0] <= AW'((AW+2)'(AngPi) - r4);
            neg_ff[NV+1] <= 1'b1;
         end else if (r4 < -(AW+2)'(AngHalfPi)) begin
            ra[0] <= AW'(-(AW+2)'(AngPi) - r4);
            neg_ff[NV+1] <= 1'b1;
         end else begin
            ra[0] <= AW'(r4);
            neg_ff[NV+1] <= 1'b0;
         end
      end
   end

   for (genvar i = 0; i < Steps; i++) begin : g_rot
      gtg_rot_stage u_rot (
         .clock, .en, .idx(5'(i)),
         .x_in(rx[i]), .y_in(ry[i]), .a_in(ra[i]),
         .x_ff(rx[i+1]), .y_ff(ry[i+1]), .a_ff(ra[i+1])
      );
   end
   for (genvar s = NV+2; s <= NT-3; s++) begin : g_dly
      always_ff @(posedge clock) begin
         if (en) begin
            dist_ff[s] <= dist_ff[s-1];
            erk_ff[s] <= erk_ff[s-1];
            ag_ff[s] <= ag_ff[s-1];
            neg_ff[s] <= neg_ff[s-1];
         end
      end
   end

   // multiply distance by cosine, and error by angular gain
   logic signed [44:0] dc_ff;
   logic signed [31:0] tp_ff;
   logic signed [20:0] cosv;
   assign cosv = neg_ff[NT-3] ? -21'(rx[Steps]) : 21'(rx[Steps]);
   logic ag2_ff, ag3_ff;
   logic [7:0] lg_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         dc_ff <= 45'($signed({1'b0, dist_ff[NT-3]})) * 45'(cosv);
         tp_ff <= 32'(erk_ff[NT-3]) * $signed({24'd0, cfg_ff.angular_gain}) + 32'sd2048;
         ag2_ff <= ag_ff[NT-3];
         lg_ff <= cfg_ff.linear_gain;
      end
   end

   logic signed [54:0] fp_ff;
   logic signed [19:0] tsh_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         fp_ff <= 55'(dc_ff) * $signed({47'd0, lg_ff}) + 55'sd8388608;
         tsh_ff <= 20'(tp_ff >>> 12);
         ag3_ff <= ag2_ff;
      end
   end

   logic signed [30:0] fsh;
   assign fsh = 31'(fp_ff >>> 24);
   logic [16:0] fwd_sat;
   logic [15:0] trn_sat;
   always_comb begin
      if (fsh > 31'sd65535) fwd_sat = 17'h0FFFF;
      else if (fsh < -31'sd65536) fwd_sat = 17'h10000;
      else fwd_sat = fsh[16:0];
      if (tsh_ff > 20'sd32767) trn_sat = 16'h7FFF;
      else if (tsh_ff < -20'sd32768) trn_sat = 16'h8000;
      else trn_sat = tsh_ff[15:0];
   end

   logic [39:0] out_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         out_ff <= ag3_ff ? {6'd0, 1'b1, 33'd0} : {6'd0, 1'b0, trn_sat, fwd_sat};
      end
   end
   assign rsp_tvalid = v_ff[NT-1];
   assign rsp_tdata = out_ff;
endmodule
`default_nettype wire

// File: rtl/gtg_vec_stage.sv
`default_nettype none
module gtg_vec_stage
   import gtg_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 en,
   input  wire logic [4:0]           idx,
   input  wire logic signed [VW-1:0] x_in,
   input  wire logic signed [VW-1:0] y_in,
   input  wire logic signed [AW-1:0] z_in,
   output logic signed [VW-1:0]      x_ff,
   output logic signed [VW-1:0]      y_ff,
   output logic signed [AW-1:0]      z_ff
);
   logic signed [VW-1:0] xs, ys;
   assign xs = x_in >>> idx;
   assign ys = y_in >>> idx;

   always_ff @(posedge clock) begin
      if (en) begin
         if (!y_in[VW-1]) begin
            x_ff <= x_in + ys;
            y_ff <= y_in - xs;
            z_ff <= z_in + atan_entry(int'(idx));
         end else begin
            x_ff <= x_in - ys;
            y_ff <= y_in + xs;
            z_ff <= z_in - atan_entry(int'(idx));
         end
      end
   end
endmodule
`default_nettype wire

// File: rtl/gtg_rot_stage.sv
`default_nettype none
module gtg_rot_stage
   import gtg_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 en,
   input  wire logic [4:0]           idx,
   input  wire logic signed [19:0]   x_in,
   input  wire logic signed [19:0]   y_in,
   input  wire logic signed [AW-1:0] a_in,
   output logic signed [19:0]        x_ff,
   output logic signed [19:0]        y_ff,
   output logic signed [AW-1:0]      a_ff
);
   logic signed [19:0] xs, ys;
   assign xs = x_in >>> idx;
   assign ys = y_in >>> idx;

   always_ff @(posedge clock) begin
      if (en) begin
         if (!a_in[AW-1]) begin
            x_ff <= x_in - ys;
            y_ff <= y_in + xs;
            a_ff <= a_in - atan_entry(int'(idx));
         end else begin
            x_ff <= x_in + ys;
            y_ff <= y_in - xs;
            a_ff <= a_in + atan_entry(int'(idx));
         end
      end
   end
endmodule
`default_nettype wire

// File: rtl/gtg_checker.sv
`default_nettype none
module gtg_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic        req_tready,
   input wire logic [39:0] rsp_tdata
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)) else $error("rsp hold");
   a_goal: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[33] |-> rsp_tdata[32:0] == '0) else $error("at_goal cmds");
   a_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[39:34] == '0) else $error("pad");
   a_rdy: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready) else $error("ready");
endmodule
bind go_to_goal_velocity_controller_core gtg_checker u_chk (.*);
`default_nettype wire

// File: tb/tb_go_to_goal_velocity_controller_core.sv
`timescale 1ns / 100ps
module tb_go_to_goal_velocity_controller_core;
   import gtg_pkg::*;

   typedef struct packed {
      logic signed [14:0] heading;
      logic signed [15:0] y;
      logic signed [15:0] x;
   } pose_type;

   typedef struct {
      logic signed [16:0] fwd;
      logic signed [15:0] turn;
      logic               at_goal;
   } cmd_type;

   localparam longint AngPiL = 205887;
   localparam longint AngHalfPiL = 102944;
   localparam longint AngTwoPiL = 411774;
   localparam longint GainL = 39797;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [39:0] rsp_tdata;
   logic        csr_we = 0;
   logic [2:0]  csr_index = '0;
   logic [15:0] csr_wdata = '0;

   pose_type pose_queue[$];
   cmd_type  cmd_queue[$];
   cfg_type  cfg;
   int       send_idle_pct = 0, recv_idle_pct = 0;
   logic     send_hold = 0, stall_go = 0;
   int       stall_cnt = 0;
   int       errors = 0, beats_in = 0, beats_out = 0, goal_hits = 0;

   go_to_goal_velocity_controller_core uut (.*);

   always #2 clock = ~clock;

   function automatic longint atan_tab(int i);
      longint t[17] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                        256, 128, 64, 32, 16, 8, 4, 2, 1};
      return (i < 17) ? t[i] : 0;
   endfunction

   function automatic cmd_type predict_cmd(pose_type p);
      cmd_type c;
      longint ex, ey, x, y, z, xs, ys, dist_q, err, a, cx, cy, sgn, fwd, turn;
      int n;
      n = (CordicSteps > 24) ? 24 : CordicSteps;
      ex = longint'(cfg.goal_x) - longint'(p.x);
      ey = longint'(cfg.goal_y) - longint'(p.y);
      x = 0; z = 0;
      if (ex != 0 || ey != 0) begin
         x = ex * 256; y = ey * 256;
         if (x < 0) begin
            z = (y >= 0) ? AngPiL : -AngPiL;
            x = -x; y = -y;
         end
         for (int i = 0; i < n; i++) begin
            xs = x >>> i; ys = y >>> i;
            if (y >= 0) begin
               x += ys; y -= xs; z += atan_tab(i);
            end else begin
               x -= ys; y += xs; z -= atan_tab(i);
            end
         end
      end
      dist_q = (x * GainL + (64'sd1 <<< 23)) >>> 24;
      if (dist_q < longint'(cfg.stop_distance)) begin
         c.fwd = '0; c.turn = '0; c.at_goal = 1;
         return c;
      end
      err = z - longint'(p.heading) * 16;
      a = err; sgn = 1; cx = GainL; cy = 0;
      for (int k = 0; k < 4; k++) begin
         if (a > AngPiL) a -= AngTwoPiL;
         else if (a < -AngPiL) a += AngTwoPiL;
      end
      if (a > AngHalfPiL) begin
         a = AngPiL - a; sgn = -1;
      end else if (a < -AngHalfPiL) begin
         a = -AngPiL - a; sgn = -1;
      end
      for (int i = 0; i < n; i++) begin
         xs = cx >>> i; ys = cy >>> i;
         if (a >= 0) begin
            cx -= ys; cy += xs; a -= atan_tab(i);
         end else begin
            cx += ys; cy -= xs; a += atan_tab(i);
         end
      end
      fwd = (dist_q * sgn * cx * longint'(cfg.linear_gain) + (64'sd1 <<< 23)) >>> 24;
      turn = (err * longint'(cfg.angular_gain) + 2048) >>> 12;
      fwd = fwd < -65536 ? -65536 : (fwd > 65535 ? 65535 : fwd);
      turn = turn < -32768 ? -32768 : (turn > 32767 ? 32767 : turn);
      c.fwd = fwd[16:0]; c.turn = turn[15:0]; c.at_goal = 0;
      return c;
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 0;
      end else if (!req_tvalid || req_tready) begin
         if (req_tvalid) begin
            cmd_queue.push_back(predict_cmd(pose_type'(req_tdata[46:0])));
            beats_in++;
         end
         if (pose_queue.size() > 0 && !send_hold && $urandom_range(99) >= send_idle_pct) begin
            req_tdata <= {1'b0, pose_queue.pop_front()};
            req_tvalid <= 1;
         end else begin
            req_tvalid <= 0;
         end
      end
   end

   // receiver
   always @(posedge clock) begin
      if (stall_go && stall_cnt == 0) begin
         stall_cnt <= 400;
         rsp_tready <= 0;
      end else if (stall_cnt > 0) begin
         stall_cnt <= stall_cnt - 1;
         rsp_tready <= (stall_cnt == 1);
      end else begin
         rsp_tready <= !reset && ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // monitor
   always @(posedge clock) begin
      cmd_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         beats_out++;
         if (cmd_queue.size() == 0) begin
            $display("%0t: unexpected beat %h", $time, rsp_tdata);
            errors++;
         end else begin
            e = cmd_queue.pop_front();
            if (e.at_goal) goal_hits++;
            if (rsp_tdata[16:0] !== e.fwd) begin
               $display("%0t: forward_speed exp %0d got %0d", $time, e.fwd,
                        $signed(rsp_tdata[16:0]));
               errors++;
            end
            if (rsp_tdata[32:17] !== e.turn) begin
               $display("%0t: turn_rate exp %0d got %0d", $time, e.turn,
                        $signed(rsp_tdata[32:17]));
               errors++;
            end
            if (rsp_tdata[33] !== e.at_goal) begin
               $display("%0t: at_goal exp %0d got %0d", $time, e.at_goal, rsp_tdata[33]);
               errors++;
            end
         end
      end
   end

   task automatic csr_write(logic [2:0] idx, logic [15:0] val);
      @(posedge clock);
      csr_we <= 1; csr_index <= idx; csr_wdata <= val;
      case (idx)
         RegGoalX:   cfg.goal_x = val;
         RegGoalY:   cfg.goal_y = val;
         RegStop:    cfg.stop_distance = val;
         RegLinGain: cfg.linear_gain = val[7:0];
         RegAngGain: cfg.angular_gain = val[7:0];
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 0;
   endtask

   task automatic drain();
      wait (pose_queue.size() == 0 && !req_tvalid && cmd_queue.size() == 0);
      repeat (60) @(posedge clock);
   endtask

   task automatic add_pose(logic [15:0] x, logic [15:0] y, logic [14:0] h);
      pose_type p;
      p.x = x; p.y = y; p.heading = h;
      pose_queue.push_back(p);
   endtask

   task automatic add_random(int count);
      int r;
      logic [15:0] x, y;
      repeat (count) begin
         r = $urandom_range(9);
         if (r < 4) begin
            x = 16'($urandom); y = 16'($urandom);
         end else if (r < 8) begin
            x = 16'(cfg.goal_x + $signed(16'($urandom_range(600))) - 300);
            y = 16'(cfg.goal_y + $signed(16'($urandom_range(600))) - 300);
         end else begin
            x = 16'(cfg.goal_x + $signed(16'($urandom_range(6))) - 3);
            y = 16'(cfg.goal_y + $signed(16'($urandom_range(6))) - 3);
         end
         add_pose(x, y, 15'($urandom));
      end
   endtask

   initial begin
      #1000000;
      $display("end of test: mismatches");
      $finish;
   end

   initial begin
      cfg = '{goal_x: 0, goal_y: 0, stop_distance: 1, linear_gain: 179, angular_gain: 128};
      repeat (9) @(posedge clock);
      reset <= 0;
      send_idle_pct = 10; recv_idle_pct = 59;

      // pose equals goal, extremes, every quadrant, odd headings
      add_pose(0, 0, 0);
      add_pose(16'h7fff, 16'h7fff, 15'h3fff);
      add_pose(16'h8000, 16'h8000, 15'h4000);
      add_pose(16'h7fff, 16'h8000, 0);
      add_pose(16'h8000, 16'h7fff, 15'h3fff);
      add_pose(16'h8000, 0, 15'h4000);
      add_pose(16'h7fff, 0, 0);
      add_pose(0, 16'h8000, 15'd12868);
      add_pose(0, 16'h7fff, -15'sd12868);
      add_pose(1, 0, 0);
      add_pose(0, 1, 0);
      add_pose(16'hffff, 16'hffff, 15'h5555);
      add_pose(16'h0400, 16'hfc00, 15'h2aaa);
      add_pose(-16'sd1024, 0, 15'h3fff);
      add_pose(-16'sd1024, 0, 15'h4000);
      add_pose(16'h5555, 16'haaaa, 15'h1234);
      add_pose(16'haaaa, 16'h5555, 15'h6dcb);
      drain();

      for (int ph = 0; ph < 9; ph++) begin
         if (ph == 3) begin
            send_idle_pct = 59; recv_idle_pct = 10;
         end else if (ph == 6) begin
            send_idle_pct = 0; recv_idle_pct = 0;
         end
         case (ph)
            0: ;
            1: begin
               csr_write(RegGoalX, 16'h7fff); csr_write(RegGoalY, 16'h8000);
               csr_write(RegStop, 0); csr_write(RegLinGain, 255);
               csr_write(RegAngGain, 255);
            end
            2: begin
               csr_write(RegGoalX, 16'h8000); csr_write(RegGoalY, 16'h7fff);
               csr_write(RegStop, 16'hffff); csr_write(RegLinGain, 0);
               csr_write(RegAngGain, 0);
            end
            3: begin
               csr_write(3'd5, 16'hffff); csr_write(3'd7, 16'h1234);
               csr_write(RegStop, 200);
            end
            default: begin
               csr_write(RegGoalX, 16'($urandom)); csr_write(RegGoalY, 16'($urandom));
               csr_write(RegStop,
                         16'($urandom_range(3) == 0 ? 0 : $urandom_range(500)));
               csr_write(RegLinGain, 16'($urandom)); csr_write(RegAngGain, 16'($urandom));
            end
         endcase
         add_random(100);
         if (ph == 4) begin
            wait (beats_in > 0 && pose_queue.size() < 80);
            stall_go <= 1;
            @(posedge clock);
            stall_go <= 0;
         end
         if (ph == 7) begin
            wait (pose_queue.size() < 50);
            send_hold <= 1;
            wait (cmd_queue.size() == 0 && !req_tvalid);
            @(posedge clock);
            send_hold <= 0;
         end
         drain();
      end

      $display("%0d poses sent, %0d commands checked, %0d at goal, over nine phases",
               beats_in, beats_out, goal_hits);
      $display("covering goal/extreme poses, gain and stop settings, stalls and bursts");
      if (errors == 0 && cmd_queue.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
